// ===== design/bsa_pkg.sv =====
package bsa_pkg;

    // Fixed widths of the channel fields
    localparam int AMOUNT_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int OP_W      = 2;
    localparam int CUST_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_RES   = 3;

    // Defaults for the top-level parameters
    localparam int DEF_CUSTOMERS  = 8;
    localparam int DEF_RESOURCES  = 3;
    localparam int DEF_COUNT_BITS = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLAIM   = 2'd0,
        OP_REQUEST = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 3'd0,
        ST_OVER_CLAIM = 3'd1,
        ST_WAIT       = 3'd2,
        ST_UNSAFE     = 3'd3,
        ST_BAD        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RD_ITEM,
        RD_SCAN_FIRST,
        RD_SCAN_NEXT
    } rd_src_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EXEC,
        S_SAFE_INIT,
        S_SAFE_SCAN,
        S_SAFE_END,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic    latch_item;
        rd_src_t rd_src;
        logic    set_status;
        status_t status_code;
        logic    claim_wr;
        logic    held_grant;
        logic    held_release;
        logic    rollback;
        logic    safe_init;
        logic    safe_step;
        logic    out_load;
    } bsa_cmd_t;

    typedef struct packed {
        logic bad_item;
        logic is_claim;
        logic is_request;
        logic claim_bad;
        logic over_need;
        logic over_free;
        logic release_bad;
        logic last_cust;
        logic last_pass;
        logic progress;
        logic all_done;
        logic out_free;
    } bsa_sts_t;

endpackage

// ===== design/bsa_ctrl.sv =====
module bsa_ctrl
    import bsa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  bsa_sts_t sts,
    output bsa_cmd_t cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd             = '0;
        cmd.rd_src      = RD_ITEM;
        cmd.status_code = ST_DONE;
        state_next      = state_reg;
        in_stall        = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.rd_src = RD_ITEM;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_FINISH;
                priority if (sts.bad_item)
                begin
                    cmd.status_code = ST_BAD;
                end
                else if (sts.is_claim)
                begin
                    if (sts.claim_bad)
                    begin
                        cmd.status_code = ST_BAD;
                    end
                    else
                    begin
                        cmd.claim_wr = 1'b1;
                    end
                end
                else if (sts.is_request)
                begin
                    priority if (sts.over_need)
                    begin
                        cmd.status_code = ST_OVER_CLAIM;
                    end
                    else if (sts.over_free)
                    begin
                        cmd.status_code = ST_WAIT;
                    end
                    else
                    begin
                        // grant tentatively, status comes after the safety scan
                        cmd.set_status = 1'b0;
                        cmd.held_grant = 1'b1;
                        state_next     = S_SAFE_INIT;
                    end
                end
                else
                begin
                    if (sts.release_bad)
                    begin
                        cmd.status_code = ST_BAD;
                    end
                    else
                    begin
                        cmd.held_release = 1'b1;
                    end
                end
            end
            S_SAFE_INIT:
            begin
                cmd.safe_init = 1'b1;
                cmd.rd_src    = RD_SCAN_FIRST;
                state_next    = S_SAFE_SCAN;
            end
            S_SAFE_SCAN:
            begin
                cmd.safe_step = 1'b1;
                cmd.rd_src    = RD_SCAN_NEXT;
                if (sts.last_cust && (!sts.progress || sts.last_pass))
                begin
                    state_next = S_SAFE_END;
                end
            end
            S_SAFE_END:
            begin
                cmd.set_status = 1'b1;
                state_next     = S_FINISH;
                if (!sts.all_done)
                begin
                    cmd.rollback    = 1'b1;
                    cmd.status_code = ST_UNSAFE;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_LOOKUP)
        else $error("accepted beat did not start a lookup");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SAFE_SCAN |=> state_reg == S_SAFE_SCAN || state_reg == S_SAFE_END)
        else $error("safety scan left by an unexpected path");

    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && !sts.out_free |=> state_reg == S_FINISH)
        else $error("result dropped while output slot busy");

endmodule

// ===== design/bsa_dp.sv =====
module bsa_dp
    import bsa_pkg::*;
#(
    parameter int CUSTOMERS  = DEF_CUSTOMERS,
    parameter int RESOURCES  = DEF_RESOURCES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AMOUNT_W-1:0]  cfg_data,
    input  logic [OP_W-1:0]      operation,
    input  logic [CUST_W-1:0]    customer,
    input  logic [AMOUNT_W-1:0]  amount_0,
    input  logic [AMOUNT_W-1:0]  amount_1,
    input  logic [AMOUNT_W-1:0]  amount_2,
    input  bsa_cmd_t             cmd,
    output bsa_sts_t             sts,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [STATUS_W-1:0]  status,
    output logic [AMOUNT_W-1:0]  free_0,
    output logic [AMOUNT_W-1:0]  free_1,
    output logic [AMOUNT_W-1:0]  free_2
);

    localparam int CIW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
    localparam int RIW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int XW  = (COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W;
    localparam logic [CIW-1:0]        LAST_IDX = CIW'(CUSTOMERS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;

    typedef logic [RESOURCES-1:0][COUNT_BITS-1:0] row_t;
    typedef logic [RESOURCES-1:0][AMOUNT_W-1:0]   amt_row_t;

    // Storage
    row_t                 claim_mem [CUSTOMERS];
    row_t                 held_mem  [CUSTOMERS];
    logic [CUSTOMERS-1:0] claim_vld_reg;
    logic [CUSTOMERS-1:0] held_vld_reg;
    row_t                 rd_claim_reg;
    row_t                 rd_held_reg;
    logic                 rd_claim_vld_reg;
    logic                 rd_held_vld_reg;

    row_t                 total_reg;
    row_t                 held_sum_reg;
    row_t                 work_reg;
    row_t                 base_held_reg;

    logic [OP_W-1:0]      item_op_reg;
    logic [CUST_W-1:0]    item_cust_reg;
    amt_row_t             item_amt_reg;

    logic [CIW-1:0]       eval_reg;
    logic [CIW-1:0]       pass_reg;
    logic                 progress_reg;
    logic [CUSTOMERS-1:0] finished_reg;

    status_t              status_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [MAX_RES-1:0][AMOUNT_W-1:0] out_free_reg;

    // Combinational
    logic [MAX_RES-1:0][AMOUNT_W-1:0] amt_all;
    logic [MAX_RES-1:0][AMOUNT_W-1:0] free_byte;
    amt_row_t             amt_in;
    row_t                 claim_row;
    row_t                 held_row;
    row_t                 free_row;
    row_t                 need_row;
    row_t                 claim_wr_row;
    row_t                 grant_row;
    row_t                 release_row;
    row_t                 sum_add_row;
    row_t                 sum_rel_row;
    row_t                 sum_back_row;
    row_t                 work_add_row;
    logic                 item_bad;
    logic                 claim_bad;
    logic                 over_need;
    logic                 over_free;
    logic                 release_bad;
    logic                 fits;
    logic                 all_fit;
    logic [CIW-1:0]       rd_addr;
    logic [CIW-1:0]       item_addr;
    logic [COUNT_BITS:0]  work_sum;

    assign amt_all = {amount_2, amount_1, amount_0};

    always_comb
    begin
        for (int r = 0; r < RESOURCES; r++)
        begin
            amt_in[r] = amt_all[r];
        end
    end

    assign item_bad = !(item_op_reg == OP_CLAIM || item_op_reg == OP_REQUEST ||
                        item_op_reg == OP_RELEASE) ||
                      (32'(item_cust_reg) >= CUSTOMERS);
    assign item_addr = item_bad ? '0 : CIW'(item_cust_reg);

    assign claim_row = rd_claim_vld_reg ? rd_claim_reg : '0;
    assign held_row  = rd_held_vld_reg  ? rd_held_reg  : '0;

    // Per-resource checks and update values
    always_comb
    begin
        claim_bad   = 1'b0;
        over_need   = 1'b0;
        over_free   = 1'b0;
        release_bad = 1'b0;
        all_fit     = 1'b1;
        work_sum    = '0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            free_row[r] = (total_reg[r] > held_sum_reg[r]) ?
                          (total_reg[r] - held_sum_reg[r]) : '0;
            need_row[r] = (claim_row[r] > held_row[r]) ?
                          (claim_row[r] - held_row[r]) : '0;
            if (XW'(item_amt_reg[r]) < XW'(held_row[r]) ||
                XW'(item_amt_reg[r]) > XW'(total_reg[r]))
            begin
                claim_bad = 1'b1;
            end
            if (XW'(item_amt_reg[r]) > XW'(need_row[r]))
            begin
                over_need = 1'b1;
            end
            if (XW'(item_amt_reg[r]) > XW'(free_row[r]))
            begin
                over_free = 1'b1;
            end
            if (XW'(item_amt_reg[r]) > XW'(held_row[r]))
            begin
                release_bad = 1'b1;
            end
            claim_wr_row[r] = COUNT_BITS'(item_amt_reg[r]);
            grant_row[r]    = held_row[r] + COUNT_BITS'(item_amt_reg[r]);
            release_row[r]  = held_row[r] - COUNT_BITS'(item_amt_reg[r]);
            sum_add_row[r]  = held_sum_reg[r] + COUNT_BITS'(item_amt_reg[r]);
            sum_back_row[r] = held_sum_reg[r] - COUNT_BITS'(item_amt_reg[r]);
            sum_rel_row[r]  = (XW'(held_sum_reg[r]) >= XW'(item_amt_reg[r])) ?
                              sum_back_row[r] : '0;
            if (need_row[r] > work_reg[r])
            begin
                all_fit = 1'b0;
            end
            // saturate the work vector at the count maximum
            work_sum        = {1'b0, work_reg[r]} + {1'b0, held_row[r]};
            work_add_row[r] = work_sum[COUNT_BITS] ? CNT_MAX : work_sum[COUNT_BITS-1:0];
        end
    end

    assign fits = !finished_reg[eval_reg] && all_fit;

    always_comb
    begin
        free_byte = '0;
        for (int r = 0; r < RESOURCES; r++)
        begin
            free_byte[r] = AMOUNT_W'(free_row[r]);
        end
    end

    always_comb
    begin
        unique case (cmd.rd_src)
            RD_ITEM:       rd_addr = item_addr;
            RD_SCAN_FIRST: rd_addr = '0;
            RD_SCAN_NEXT:  rd_addr = (eval_reg == LAST_IDX) ? '0 : eval_reg + 1'b1;
            default:       rd_addr = '0;
        endcase
    end

    // Tables: one row per customer, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.claim_wr)
        begin
            claim_mem[item_addr] <= claim_wr_row;
        end
        if (cmd.held_grant)
        begin
            held_mem[item_addr] <= grant_row;
        end
        else if (cmd.held_release)
        begin
            held_mem[item_addr] <= release_row;
        end
        else if (cmd.rollback)
        begin
            held_mem[item_addr] <= base_held_reg;
        end
        rd_claim_reg <= claim_mem[rd_addr];
        rd_held_reg  <= held_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claim_vld_reg    <= '0;
            held_vld_reg     <= '0;
            rd_claim_vld_reg <= 1'b0;
            rd_held_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.claim_wr)
            begin
                claim_vld_reg[item_addr] <= 1'b1;
            end
            if (cmd.held_grant || cmd.held_release || cmd.rollback)
            begin
                held_vld_reg[item_addr] <= 1'b1;
            end
            rd_claim_vld_reg <= claim_vld_reg[rd_addr];
            rd_held_vld_reg  <= held_vld_reg[rd_addr];
        end
    end

    // Totals and held sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            held_sum_reg <= '0;
        end
        else
        begin
            if (cfg_valid && (32'(cfg_index) < RESOURCES))
            begin
                total_reg[RIW'(cfg_index)] <= COUNT_BITS'(cfg_data);
            end
            if (cmd.held_grant)
            begin
                held_sum_reg <= sum_add_row;
            end
            else if (cmd.held_release)
            begin
                held_sum_reg <= sum_rel_row;
            end
            else if (cmd.rollback)
            begin
                held_sum_reg <= sum_back_row;
            end
        end
    end

    // Item latch, grant snapshot, work vector
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_op_reg   <= operation;
            item_cust_reg <= customer;
            item_amt_reg  <= amt_in;
        end
        if (cmd.held_grant)
        begin
            base_held_reg <= held_row;
        end
        if (cmd.safe_init)
        begin
            work_reg <= free_row;
        end
        else if (cmd.safe_step && fits)
        begin
            work_reg <= work_add_row;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_free_reg   <= free_byte;
        end
    end

    // Safety scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg     <= '0;
            pass_reg     <= '0;
            progress_reg <= 1'b0;
            finished_reg <= '0;
        end
        else if (cmd.safe_init)
        begin
            eval_reg     <= '0;
            pass_reg     <= '0;
            progress_reg <= 1'b0;
            finished_reg <= '0;
        end
        else if (cmd.safe_step)
        begin
            if (fits)
            begin
                finished_reg[eval_reg] <= 1'b1;
            end
            if (eval_reg == LAST_IDX)
            begin
                eval_reg     <= '0;
                pass_reg     <= pass_reg + 1'b1;
                progress_reg <= 1'b0;
            end
            else
            begin
                eval_reg     <= eval_reg + 1'b1;
                progress_reg <= progress_reg | fits;
            end
        end
    end

    // Output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.bad_item    = item_bad;
    assign sts.is_claim    = (item_op_reg == OP_CLAIM);
    assign sts.is_request  = (item_op_reg == OP_REQUEST);
    assign sts.claim_bad   = claim_bad;
    assign sts.over_need   = over_need;
    assign sts.over_free   = over_free;
    assign sts.release_bad = release_bad;
    assign sts.last_cust   = (eval_reg == LAST_IDX);
    assign sts.last_pass   = (pass_reg == LAST_IDX);
    assign sts.progress    = progress_reg | fits;
    assign sts.all_done    = &finished_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign free_0    = out_free_reg[0];
    assign free_1    = out_free_reg[1];
    assign free_2    = out_free_reg[2];

    a_finished_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.safe_step |=> (finished_reg & $past(finished_reg)) == $past(finished_reg))
        else $error("finished customer lost during safety scan");

    a_stall_pass_stable: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.safe_step && sts.last_cust && !sts.progress
        |=> finished_reg == $past(finished_reg))
        else $error("pass without progress changed the finished set");

endmodule

// ===== design/bankers_safe_allocator_unit.sv =====
// Banker's-algorithm allocator for up to three resource types.
//
// Input channel (in_valid / in_stall): one beat carries operation, customer
// and three amounts: declare a maximum claim, request units or release units.
// Output channel (out_valid / out_stall): exactly one beat per input beat,
// carrying status and the free units of each resource type after the step.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index selects
// total_0..total_2, cfg_data is the new total. Write it only while idle.
//
// Claim, release and rejected beats pass through lookup, check and result;
// a granted request adds the safety scan, at most CUSTOMERS passes over
// the customer rows, before its result. The scan evaluates one customer
// row per cycle through the single read port of the tables.
// One beat is in work at a time; in_stall is low only between beats, and the
// next beat may enter while the previous result still waits at the output.
//
// Reset clears totals, claims, holdings and the output slot at once.
// A stalled result holds in the output register; the next result waits in
// the status register, with the controller in S_FINISH, until the slot frees.
module bankers_safe_allocator_unit
    import bsa_pkg::*;
#(
    parameter int CUSTOMERS  = DEF_CUSTOMERS,
    parameter int RESOURCES  = DEF_RESOURCES,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [AMOUNT_W-1:0]  cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OP_W-1:0]      operation,
    input  logic [CUST_W-1:0]    customer,
    input  logic [AMOUNT_W-1:0]  amount_0,
    input  logic [AMOUNT_W-1:0]  amount_1,
    input  logic [AMOUNT_W-1:0]  amount_2,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [AMOUNT_W-1:0]  free_0,
    output logic [AMOUNT_W-1:0]  free_1,
    output logic [AMOUNT_W-1:0]  free_2
);

    bsa_cmd_t cmd;
    bsa_sts_t sts;

    // Totals are plain registers: accept every config beat.
    assign cfg_ready = 1'b1;

    // Sequence each beat: lookup, check, optional safety scan, result.
    bsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold tables, totals, work vector and the output slot.
    bsa_dp #(
        .CUSTOMERS  (CUSTOMERS),
        .RESOURCES  (RESOURCES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .customer  (customer),
        .amount_0  (amount_0),
        .amount_1  (amount_1),
        .amount_2  (amount_2),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .status    (status),
        .free_0    (free_0),
        .free_1    (free_1),
        .free_2    (free_2)
    );

endmodule
